@@ rtl/etrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etrb_pkg: shared types and sizes for the event trace ring buffer
// Holds the ring depth, derived pointer and count widths, and the
// entry layout used by the top level.
// ----------------------------------------------------------------------------
package etrb_pkg;

   // ring capacity and derived widths
   localparam int DEPTH   = 64;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // field widths of one trace entry
   localparam int TS_W    = 32;
   localparam int EV_W    = 8;
   localparam int TASK_W  = 16;
   localparam int CPU_W   = 4;
   localparam int CSR_W   = 7;

   // request action codes
   localparam logic ACT_LOG  = 1'b0;
   localparam logic ACT_DUMP = 1'b1;

   // one stored trace entry
   typedef struct packed {
      logic [TS_W-1:0]   ts;
      logic [EV_W-1:0]   ev;
      logic [TASK_W-1:0] task_id;
      logic [CPU_W-1:0]  cpu;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // ram write request from the controller
   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
   } wr_req_type;

   // ram read request from the dump sequencer
   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      logic             last;
   } rd_req_type;

endpackage
`default_nettype wire

@@ rtl/etrb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etrb_ram: generic simple dual-port ram
// One write port and one read port, read data registered on a read.
// ----------------------------------------------------------------------------
module etrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/etrb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etrb_ctrl: ring pointer, fill count and dump sequencer
// Tracks the write pointer and fill level, turns log beats into ram
// writes and walks the ring oldest first on a dump, one read per credit.
// ----------------------------------------------------------------------------
module etrb_ctrl
   import etrb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_action,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_depth_in_use,
   input  wire logic             issue_ok,
   output wr_req_type            wr_req,
   output rd_req_type            rd_req
);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type        state_ff,  state_in;
   logic [CNT_W-1:0] depth_ff,  depth_in;
   logic [PTR_W-1:0] wp_ff,     wp_in;
   logic [CNT_W-1:0] fill_ff,   fill_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] remain_ff, remain_in;

   logic             accept;
   logic             enabled;
   logic [CNT_W-1:0] wp_inc;
   logic [CNT_W-1:0] rd_inc;
   logic [CNT_W-1:0] depth_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign enabled   = (depth_ff != '0);
   assign wp_inc    = CNT_W'(wp_ff) + CNT_W'(1);
   assign rd_inc    = CNT_W'(rd_ptr_ff) + CNT_W'(1);

   // clamp the written depth to the ring capacity
   assign depth_sat = (32'(csr_depth_in_use) > 32'(DEPTH)) ? CNT_W'(DEPTH)
                                                            : CNT_W'(csr_depth_in_use);

   // ram requests
   assign wr_req.en   = accept && (req_action == ACT_LOG) && enabled;
   assign wr_req.addr = wp_ff;
   assign rd_req.en   = (state_ff == ST_DUMP) && issue_ok;
   assign rd_req.addr = rd_ptr_ff;
   assign rd_req.last = (remain_ff == CNT_W'(1));

   // next-state logic
   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      rd_ptr_in = rd_ptr_ff;
      remain_in = remain_ff;
      case (state_ff)
         ST_IDLE: begin
            // log: store and advance, fill saturates at depth
            if (wr_req.en) begin
               wp_in = (wp_inc == depth_ff) ? '0 : wp_inc[PTR_W-1:0];
               if (fill_ff < depth_ff) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            // dump: start at oldest entry, nothing to do when empty
            if (accept && (req_action == ACT_DUMP) && enabled && (fill_ff != '0)) begin
               state_in  = ST_DUMP;
               rd_ptr_in = (fill_ff < depth_ff) ? '0 : wp_ff;
               remain_in = fill_ff;
            end
         end
         ST_DUMP: begin
            if (rd_req.en) begin
               rd_ptr_in = (rd_inc == depth_ff) ? '0 : rd_inc[PTR_W-1:0];
               remain_in = remain_ff - CNT_W'(1);
               if (rd_req.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // depth write empties the ring
      if (csr_wr_en) begin
         depth_in = depth_sat;
         wp_in    = '0;
         fill_in  = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         depth_ff  <= '0;
         wp_ff     <= '0;
         fill_ff   <= '0;
         rd_ptr_ff <= '0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         depth_ff  <= depth_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         rd_ptr_ff <= rd_ptr_in;
         remain_ff <= remain_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/event_trace_ring_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_trace_ring_buffer: circular trace buffer, oldest entry overwritten
// Stores trace entries in a ram ring and dumps them oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per operation. action log stores the entry at
//   the write pointer and never answers; one log beat is taken per cycle
//   outside a dump. action dump streams every stored entry, oldest first,
//   on rsp_*, with rsp_last on the newest one; an empty ring or a depth
//   of zero answers nothing. The dump state, the registered ram read and
//   the output queue precede the first rsp beat, then one beat per cycle
//   while rsp_ready is high. req_ready stays low from the dump beat until
//   the last ram read issues; the rate is set by the single ram read port.
//   csr_wr_en writes depth_in_use (clamped to the ring size) and empties
//   the ring; write it only when no dump is pending.
//   Reset clears the depth to zero (logging off), the write pointer and
//   the fill count; ram contents are not cleared and are never read
//   before being written.
//   When rsp_ready is low, a two-entry output queue holds results and the
//   dump sequencer only issues reads that the queue has room for.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer
   import etrb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_action,
   input  wire logic [TS_W-1:0]   req_timestamp,
   input  wire logic [EV_W-1:0]   req_event_code,
   input  wire logic [TASK_W-1:0] req_task_id,
   input  wire logic [CPU_W-1:0]  req_cpu_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [TS_W-1:0]   rsp_rec_timestamp,
   output logic      [EV_W-1:0]   rsp_rec_event,
   output logic      [TASK_W-1:0] rsp_rec_task,
   output logic      [CPU_W-1:0]  rsp_rec_cpu,
   output logic                   rsp_last,
   input  wire logic              csr_wr_en,
   input  wire logic [CSR_W-1:0]  csr_depth_in_use
);

   wr_req_type  wr_req;
   rd_req_type  rd_req;
   entry_type   wr_entry;
   entry_type   rd_entry;
   logic        issue_ok;

   logic        inflight_ff;
   logic        inflight_last_ff;
   logic [1:0]  occ_ff, occ_in;
   entry_type   q0_ff, q1_ff;
   logic        q0_last_ff, q1_last_ff;
   logic        push;
   logic        pop;
   logic [2:0]  room_use;

   // controller
   etrb_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .csr_wr_en        (csr_wr_en),
      .csr_depth_in_use (csr_depth_in_use),
      .issue_ok         (issue_ok),
      .wr_req           (wr_req),
      .rd_req           (rd_req)
   );

   // entry store
   assign wr_entry.ts      = req_timestamp;
   assign wr_entry.ev      = req_event_code;
   assign wr_entry.task_id = req_task_id;
   assign wr_entry.cpu     = req_cpu_index;

   etrb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_req.en),
      .wr_addr (wr_req.addr),
      .wr_data (wr_entry),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_entry)
   );

   // read in flight, last flag rides along with it
   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
      end else begin
         inflight_ff <= rd_req.en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         inflight_last_ff <= rd_req.last;
      end
   end

   // credit: queue entries plus in-flight read must fit in two slots
   assign push     = inflight_ff;
   assign pop      = rsp_valid && rsp_ready;
   assign room_use = 3'(occ_ff) + 3'(inflight_ff) - 3'(pop);
   assign issue_ok = (room_use < 3'd2);
   assign occ_in   = 2'(3'(occ_ff) + 3'(push) - 3'(pop));

   // output queue occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // output queue payload
   always_ff @(posedge clock) begin
      case (occ_ff)
         2'd0: begin
            if (push) begin
               q0_ff      <= rd_entry;
               q0_last_ff <= inflight_last_ff;
            end
         end
         2'd1: begin
            if (push && pop) begin
               q0_ff      <= rd_entry;
               q0_last_ff <= inflight_last_ff;
            end else if (push) begin
               q1_ff      <= rd_entry;
               q1_last_ff <= inflight_last_ff;
            end
         end
         2'd2: begin
            if (pop) begin
               q0_ff      <= q1_ff;
               q0_last_ff <= q1_last_ff;
               if (push) begin
                  q1_ff      <= rd_entry;
                  q1_last_ff <= inflight_last_ff;
               end
            end
         end
         default: begin
            q0_ff      <= q0_ff;
            q0_last_ff <= q0_last_ff;
         end
      endcase
   end

   // response ports
   assign rsp_valid         = (occ_ff != '0);
   assign rsp_rec_timestamp = q0_ff.ts;
   assign rsp_rec_event     = q0_ff.ev;
   assign rsp_rec_task      = q0_ff.task_id;
   assign rsp_rec_cpu       = q0_ff.cpu;
   assign rsp_last          = q0_last_ff;

endmodule
`default_nettype wire

@@ rtl/etrb_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etrb_chk: port-level checks for the event trace ring buffer
// Watches the top-level handshakes and flags misbehavior over time.
// ----------------------------------------------------------------------------
module etrb_chk
   import etrb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_action,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [TS_W-1:0]   rsp_rec_timestamp,
   input wire logic [EV_W-1:0]   rsp_rec_event,
   input wire logic [TASK_W-1:0] rsp_rec_task,
   input wire logic [CPU_W-1:0]  rsp_rec_cpu,
   input wire logic              rsp_last
);

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rec_timestamp)
         && $stable(rsp_rec_event) && $stable(rsp_rec_task)
         && $stable(rsp_rec_cpu) && $stable(rsp_last)))
      else $error("stalled result beat changed");

   // the request side only stalls after a dump beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && (req_action == ACT_DUMP)))
      else $error("request stall without a dump beat");

   // a log beat never stalls the next one
   a_log_rate: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACT_LOG)) |=> req_ready)
      else $error("log beat stalled the request side");

endmodule

bind event_trace_ring_buffer etrb_chk u_etrb_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_rec_timestamp (rsp_rec_timestamp),
   .rsp_rec_event     (rsp_rec_event),
   .rsp_rec_task      (rsp_rec_task),
   .rsp_rec_cpu       (rsp_rec_cpu),
   .rsp_last          (rsp_last)
);
`default_nettype wire

@@ tb/tb_event_trace_ring_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_trace_ring_buffer: self-checking bench for the trace ring buffer
// Feeds log and dump beats with random gaps on both channels, predicts every
// dumped entry with a small software ring, and compares each rsp beat field
// by field. Depth is rewritten between phases, including zero and values
// above the ring size.
// ----------------------------------------------------------------------------
module tb_event_trace_ring_buffer
   import etrb_pkg::*;
();

   localparam int RAND_ITEMS    = 450;
   localparam int SETTLE_CYCLES = 8;

   // one request beat as queued for the driver
   typedef struct packed {
      logic      action;
      entry_type fields;
   } trace_req_type;

   // one expected dump beat
   typedef struct packed {
      entry_type fields;
      logic      last;
   } dump_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = ACT_LOG;
   logic [TS_W-1:0]   req_timestamp = '0;
   logic [EV_W-1:0]   req_event_code = '0;
   logic [TASK_W-1:0] req_task_id = '0;
   logic [CPU_W-1:0]  req_cpu_index = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [TS_W-1:0]   rsp_rec_timestamp;
   logic [EV_W-1:0]   rsp_rec_event;
   logic [TASK_W-1:0] rsp_rec_task;
   logic [CPU_W-1:0]  rsp_rec_cpu;
   logic              rsp_last;
   logic              csr_wr_en = 1'b0;
   logic [CSR_W-1:0]  csr_depth_in_use = '0;

   // predicted ring contents and pointers
   entry_type   trace_ram [DEPTH];
   int unsigned ring_depth = 0;
   int unsigned wr_ptr = 0;
   int unsigned fill_level = 0;

   trace_req_type pending_q[$];
   dump_beat_type dump_expect_q[$];
   trace_req_type seen_req;
   dump_beat_type want_beat;
   trace_req_type next_req;

   logic req_fire = 1'b0;
   logic no_idle = 1'b0;
   int   error_count = 0;
   int   beats_checked = 0;
   int   events_sent = 0;
   int   rand_items = 0;
   int   depth_writes = 0;
   int unsigned gen_depth = 0;

   event_trace_ring_buffer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_timestamp     (req_timestamp),
      .req_event_code    (req_event_code),
      .req_task_id       (req_task_id),
      .req_cpu_index     (req_cpu_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rec_timestamp (rsp_rec_timestamp),
      .rsp_rec_event     (rsp_rec_event),
      .rsp_rec_task      (rsp_rec_task),
      .rsp_rec_cpu       (rsp_rec_cpu),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_depth_in_use  (csr_depth_in_use)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // depth write clamps to the ring size and empties the ring
   task automatic apply_depth(input logic [CSR_W-1:0] value);
      ring_depth = (value > DEPTH) ? DEPTH : value;
      wr_ptr     = 0;
      fill_level = 0;
   endtask

   // log stores at the write pointer; dump lists entries oldest first
   task automatic predict_trace(input trace_req_type r);
      int unsigned first;
      dump_beat_type b;
      if (ring_depth != 0) begin
         if (r.action == ACT_LOG) begin
            trace_ram[wr_ptr] = r.fields;
            wr_ptr = (wr_ptr + 1) % ring_depth;
            if (fill_level < ring_depth) fill_level++;
         end else begin
            first = (fill_level < ring_depth) ? 0 : wr_ptr;
            for (int unsigned i = 0; i < fill_level; i++) begin
               b.fields = trace_ram[(first + i) % ring_depth];
               b.last   = (i + 1 == fill_level);
               dump_expect_q.push_back(b);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor: predictor update and rsp beat check at the rising edge
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      if (reset) begin
         apply_depth('0);
         dump_expect_q.delete();
      end else begin
         if (csr_wr_en) apply_depth(csr_depth_in_use);
         if (req_valid && req_ready) begin
            seen_req.action         = req_action;
            seen_req.fields.ts      = req_timestamp;
            seen_req.fields.ev      = req_event_code;
            seen_req.fields.task_id = req_task_id;
            seen_req.fields.cpu     = req_cpu_index;
            predict_trace(seen_req);
         end
         if (rsp_valid && rsp_ready) begin
            if (dump_expect_q.size() == 0) begin
               $display({"%0t ns: unexpected rsp beat, expected none, ",
                         "got ts %h ev %h task %h cpu %h last %b"},
                        $time, rsp_rec_timestamp, rsp_rec_event, rsp_rec_task,
                        rsp_rec_cpu, rsp_last);
               error_count++;
            end else begin
               want_beat = dump_expect_q.pop_front();
               check_field("rec_timestamp", want_beat.fields.ts, rsp_rec_timestamp);
               check_field("rec_event", 32'(want_beat.fields.ev), 32'(rsp_rec_event));
               check_field("rec_task", 32'(want_beat.fields.task_id),
                           32'(rsp_rec_task));
               check_field("rec_cpu", 32'(want_beat.fields.cpu), 32'(rsp_rec_cpu));
               check_field("last", 32'(want_beat.last), 32'(rsp_last));
               beats_checked++;
            end
         end
      end
   end

   // driver: next req beat once the current one is taken
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 26);
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
            next_req = pending_q.pop_front();
            req_action     <= next_req.action;
            req_timestamp  <= next_req.fields.ts;
            req_event_code <= next_req.fields.ev;
            req_task_id    <= next_req.fields.task_id;
            req_cpu_index  <= next_req.fields.cpu;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic queue_event(input logic act, input logic [TS_W-1:0] ts,
                              input logic [EV_W-1:0] ev, input logic [TASK_W-1:0] tid,
                              input logic [CPU_W-1:0] cpu);
      trace_req_type r;
      r.action         = act;
      r.fields.ts      = ts;
      r.fields.ev      = ev;
      r.fields.task_id = tid;
      r.fields.cpu     = cpu;
      pending_q.push_back(r);
      events_sent++;
      if (gen_depth != 0) rand_items++;
   endtask

   task automatic queue_random(input logic act);
      queue_event(act, $urandom, EV_W'($urandom_range(0, 255)),
                  TASK_W'($urandom_range(0, 65535)), CPU_W'($urandom_range(0, 15)));
   endtask

   // wait until every beat is sent and answered, then let the ram settle
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_q.size() != 0 || req_valid || dump_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_depth(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_depth_in_use <= value;
      csr_wr_en        <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gen_depth = (value > DEPTH) ? DEPTH : value;
      depth_writes++;
      @(posedge clock);
      #1;
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("event_trace_ring_buffer: mismatch");
      $finish;
   end

   // stimulus sequence
   initial begin
      int          phase;
      int          n_items;
      logic [CSR_W-1:0] depth_val;
      phase = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // depth zero out of reset: log and dump are both ignored
      queue_event(ACT_LOG, '1, '1, '1, '1);
      queue_event(ACT_DUMP, '1, '1, '1, '1);
      wait_idle();

      // single entry ring: empty dump, all ones, all zeros
      write_depth(7'd1);
      queue_event(ACT_DUMP, '0, '0, '0, '0);
      queue_event(ACT_LOG, '1, '1, '1, '1);
      queue_event(ACT_DUMP, 32'h5a5a_a5a5, 8'h3c, 16'hc3c3, 4'h9);
      queue_event(ACT_LOG, '0, '0, '0, '0);
      queue_event(ACT_DUMP, '0, '0, '0, '0);
      wait_idle();

      // three entry ring overwritten past its end, dumped twice
      write_depth(7'd3);
      for (int i = 1; i <= 5; i++)
         queue_event(ACT_LOG, TS_W'(i * 32'h1111_1111), EV_W'(i * 8'h11),
                     TASK_W'(i * 16'h1111), i[3:0]);
      queue_event(ACT_DUMP, '0, '0, '0, '0);
      queue_event(ACT_DUMP, '1, '1, '1, '1);
      wait_idle();

      // depth above the ring size saturates
      write_depth(7'd127);
      repeat (3) queue_random(ACT_LOG);
      queue_event(ACT_DUMP, '0, '0, '0, '0);
      wait_idle();

      // logging switched off again
      write_depth(7'd0);
      queue_random(ACT_LOG);
      queue_random(ACT_DUMP);
      wait_idle();

      // random phases, each with a fresh depth
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         case ($urandom_range(0, 11))
            0:       depth_val = 7'd0;
            1:       depth_val = 7'd1;
            2:       depth_val = 7'd64;
            3:       depth_val = 7'd127;
            4:       depth_val = 7'd2;
            5:       depth_val = CSR_W'($urandom_range(65, 126));
            default: depth_val = CSR_W'($urandom_range(1, 64));
         endcase
         no_idle = (phase == 2) || ($urandom_range(0, 5) == 0);
         write_depth(depth_val);
         n_items = $urandom_range(4, 2 * gen_depth + 8);
         // keep the total near the planned item count
         if (n_items > RAND_ITEMS - rand_items) n_items = RAND_ITEMS - rand_items;
         for (int k = 0; k < n_items; k++)
            queue_random(($urandom_range(0, 7) == 0) ? ACT_DUMP : ACT_LOG);
         queue_random(ACT_DUMP);
         wait_idle();
         phase++;
      end
      no_idle = 1'b0;

      $display("run covered %0d req beats over %0d depth settings", events_sent,
               depth_writes);
      $display("%0d dump beats compared, %0d field errors", beats_checked, error_count);
      if (error_count == 0 && dump_expect_q.size() == 0) begin
         $display("event_trace_ring_buffer: match");
      end else begin
         $display("event_trace_ring_buffer: mismatch");
      end
      $finish;
   end

endmodule
